### src/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray/triangle intersection unit
// Holds the default widths, register indexes and the control word that
// travels down the pipeline next to the data.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int CoordWidthDef = 20;
  localparam int DistWidthDef  = 32;
  localparam int MinWidth      = 17;
  localparam int CfgIdxWidth   = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_VERTEX_A       = 3'd0,
    REG_VERTEX_B       = 3'd1,
    REG_VERTEX_C       = 3'd2,
    REG_SURFACE_NORMAL = 3'd3,
    REG_MIN_PRIMARY    = 3'd4,
    REG_MIN_SHADOW     = 3'd5
  } reg_idx_e;

  // Control word of one pipeline slot.
  typedef struct packed {
    logic valid;   // slot holds an item
    logic shadow;  // shadow query
    logic live;    // still a candidate hit
    logic ovf;     // quotient does not fit the distance format
  } ctl_t;

  // Width of a 3x3 determinant of coordinate differences.
  function automatic int det_width(int cw);
    return 3 * cw + 6;
  endfunction

endpackage

### src/rti_det.sv
// ----------------------------------------------------------------------------
// rti_det: determinant pipeline
// Six stages: coordinate differences, 2x2 products, 2x2 minors, split
// partial products, term assembly and the final sums of det, Db, Dg, Dt.
// ----------------------------------------------------------------------------
module rti_det #(
  parameter int CW = rti_pkg::CoordWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  rti_pkg::ctl_t                          ctl_i,
  input  logic [6*CW-1:0]                        side_i,
  input  logic [3*CW-1:0]                        vtx_a_i,
  input  logic [3*CW-1:0]                        vtx_b_i,
  input  logic [3*CW-1:0]                        vtx_c_i,
  output rti_pkg::ctl_t                          ctl_o,
  output logic [6*CW-1:0]                        side_o,
  output logic signed [rti_pkg::det_width(CW)-1:0] det_o,
  output logic signed [rti_pkg::det_width(CW)-1:0] db_o,
  output logic signed [rti_pkg::det_width(CW)-1:0] dg_o,
  output logic signed [rti_pkg::det_width(CW)-1:0] dt_o
);
  import rti_pkg::*;

  localparam int DIFW  = CW + 1;
  localparam int PRW   = 2 * DIFW;
  localparam int MINW  = 2 * DIFW + 1;
  localparam int LO    = MINW / 2;
  localparam int HIW   = MINW - LO;
  localparam int PLW   = DIFW + LO + 1;
  localparam int PHW   = DIFW + HIW;
  localparam int TERMW = DIFW + MINW;
  localparam int DETW  = det_width(CW);
  localparam int NST   = 6;

  ctl_t            ctl_q  [NST];
  logic [6*CW-1:0] side_q [NST];

  logic signed [DIFW-1:0]  c1_d [3], c2_d [3], rv_d [3], dv_d [3];
  logic signed [DIFW-1:0]  c1_q [3], c2_q [3], rv_q [3], dv_q [3];
  logic signed [DIFW-1:0]  c1_2q [3], rv_2q [3], c1_3q [3], rv_3q [3];
  logic signed [DIFW-1:0]  pv [3][3], pw [3][3];
  logic signed [PRW-1:0]   pa_d [3][3], pb_d [3][3], pa_q [3][3], pb_q [3][3];
  logic signed [MINW-1:0]  mn_d [3][3], mn_q [3][3];
  logic signed [PLW-1:0]   pl_d [4][3], pl_q [4][3];
  logic signed [PHW-1:0]   ph_d [4][3], ph_q [4][3];
  logic signed [TERMW-1:0] tm_d [4][3], tm_q [4][3];
  logic signed [DETW-1:0]  dd_d [4], dd_q [4];

  // Stage 1: edge vectors A-B, A-C, A-O and the direction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1_d[i] = DIFW'($signed(vtx_a_i[3*CW-1-i*CW -: CW]))
              - DIFW'($signed(vtx_b_i[3*CW-1-i*CW -: CW]));
      c2_d[i] = DIFW'($signed(vtx_a_i[3*CW-1-i*CW -: CW]))
              - DIFW'($signed(vtx_c_i[3*CW-1-i*CW -: CW]));
      rv_d[i] = DIFW'($signed(vtx_a_i[3*CW-1-i*CW -: CW]))
              - DIFW'($signed(side_i[6*CW-1-i*CW -: CW]));
      dv_d[i] = DIFW'($signed(side_i[3*CW-1-i*CW -: CW]));
    end
  end

  // Stage 2: products of the minors for the column pairs (C2,D), (R,D), (C2,R).
  always_comb begin
    int r;
    int s;
    for (int k = 0; k < 3; k++) begin
      pv[0][k] = c2_q[k];
      pw[0][k] = dv_q[k];
      pv[1][k] = rv_q[k];
      pw[1][k] = dv_q[k];
      pv[2][k] = c2_q[k];
      pw[2][k] = rv_q[k];
    end
    for (int p = 0; p < 3; p++) begin
      for (int j = 0; j < 3; j++) begin
        r = (j == 0) ? 1 : 0;
        s = (j == 2) ? 1 : 2;
        pa_d[p][j] = PRW'(pv[p][r]) * PRW'(pw[p][s]);
        pb_d[p][j] = PRW'(pw[p][r]) * PRW'(pv[p][s]);
      end
    end
  end

  // Stage 3: minors.
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int j = 0; j < 3; j++) begin
        mn_d[p][j] = MINW'(pa_q[p][j]) - MINW'(pb_q[p][j]);
      end
    end
  end

  // Stage 4: cofactor products, each minor split into a low and a high half.
  // Determinant k: 0 det (C1, pair 0), 1 Db (R, pair 0), 2 Dg (C1, pair 1),
  // 3 Dt (C1, pair 2).
  always_comb begin
    logic signed [DIFW-1:0] u;
    logic signed [MINW-1:0] m;
    int pr;
    for (int k = 0; k < 4; k++) begin
      pr = (k < 2) ? 0 : k - 1;
      for (int j = 0; j < 3; j++) begin
        u = (k == 1) ? rv_3q[j] : c1_3q[j];
        m = mn_q[pr][j];
        pl_d[k][j] = PLW'(u) * PLW'($signed({1'b0, m[LO-1:0]}));
        ph_d[k][j] = PHW'(u) * PHW'($signed(m[MINW-1:LO]));
      end
    end
  end

  // Stage 5 and 6: reassemble the terms, then sum with alternating signs.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        tm_d[k][j] = (TERMW'(ph_q[k][j]) <<< LO) + TERMW'(pl_q[k][j]);
      end
      dd_d[k] = DETW'(tm_q[k][0]) - DETW'(tm_q[k][1]) + DETW'(tm_q[k][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NST; n++) ctl_q[n] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int n = 1; n < NST; n++) ctl_q[n] <= ctl_q[n-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int n = 1; n < NST; n++) side_q[n] <= side_q[n-1];
      c1_q  <= c1_d;
      c2_q  <= c2_d;
      rv_q  <= rv_d;
      dv_q  <= dv_d;
      c1_2q <= c1_q;
      rv_2q <= rv_q;
      c1_3q <= c1_2q;
      rv_3q <= rv_2q;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      mn_q  <= mn_d;
      pl_q  <= pl_d;
      ph_q  <= ph_d;
      tm_q  <= tm_d;
      dd_q  <= dd_d;
    end
  end

  assign ctl_o  = ctl_q[NST-1];
  assign side_o = side_q[NST-1];
  assign det_o  = dd_q[0];
  assign db_o   = dd_q[1];
  assign dg_o   = dd_q[2];
  assign dt_o   = dd_q[3];

endmodule

### src/rti_check.sv
// ----------------------------------------------------------------------------
// rti_check: sign normalization and hit tests
// Makes the determinant positive, tests the barycentric and distance signs,
// detects quotient overflow and prepares the divider operands.
// ----------------------------------------------------------------------------
module rti_check #(
  parameter int CW    = rti_pkg::CoordWidthDef,
  parameter int DISTW = rti_pkg::DistWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  rti_pkg::ctl_t                          ctl_i,
  input  logic [6*CW-1:0]                        side_i,
  input  logic signed [rti_pkg::det_width(CW)-1:0] det_i,
  input  logic signed [rti_pkg::det_width(CW)-1:0] db_i,
  input  logic signed [rti_pkg::det_width(CW)-1:0] dg_i,
  input  logic signed [rti_pkg::det_width(CW)-1:0] dt_i,
  output rti_pkg::ctl_t                          ctl_o,
  output logic [6*CW-1:0]                        side_o,
  output logic [rti_pkg::det_width(CW)-1:0]      rem_o,
  output logic [rti_pkg::det_width(CW)-1:0]      div_o,
  output logic [DISTW-1:0]                       feed_o
);
  import rti_pkg::*;

  localparam int DETW = det_width(CW);
  localparam int NEGW = DETW + 1;
  localparam int DF   = DISTW / 2;
  localparam int SH   = DISTW - DF;
  localparam int CMW  = NEGW + SH;

  ctl_t                   ctl7_d, ctl7_q, ctl8_d, ctl8_q;
  logic [6*CW-1:0]        side7_q, side8_q;
  logic signed [NEGW-1:0] det_d, db_d, dg_d, dt_d;
  logic signed [NEGW-1:0] det_q, db_q, dg_q, dt_q;
  logic signed [NEGW:0]   sum;
  logic [DETW-1:0]        rem_d, rem_q, div_d, div_q;
  logic [DISTW-1:0]       feed_d, feed_q;
  logic                   neg;

  // Stage 7: flip all four signs when det is negative.
  always_comb begin
    neg         = det_i[DETW-1];
    det_d       = neg ? -NEGW'(det_i) : NEGW'(det_i);
    db_d        = neg ? -NEGW'(db_i)  : NEGW'(db_i);
    dg_d        = neg ? -NEGW'(dg_i)  : NEGW'(dg_i);
    dt_d        = neg ? -NEGW'(dt_i)  : NEGW'(dt_i);
    ctl7_d      = ctl_i;
    ctl7_d.live = ctl_i.live && (det_i != '0);
  end

  // Stage 8: inside test, sign of t, overflow and divider setup.
  always_comb begin
    sum         = (NEGW+1)'(db_q) + (NEGW+1)'(dg_q);
    ctl8_d      = ctl7_q;
    ctl8_d.live = ctl7_q.live && !db_q[NEGW-1] && !dg_q[NEGW-1] && !dt_q[NEGW-1]
                  && (sum <= (NEGW+1)'(det_q));
    ctl8_d.ovf  = CMW'($unsigned(dt_q)) >= (CMW'($unsigned(det_q)) << SH);
    rem_d       = DETW'($unsigned(dt_q) >> SH);
    div_d       = DETW'($unsigned(det_q));
    feed_d      = {dt_q[SH-1:0], {DF{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl7_q <= '0;
      ctl8_q <= '0;
    end else if (en_i) begin
      ctl7_q <= ctl7_d;
      ctl8_q <= ctl8_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side7_q <= side_i;
      det_q   <= det_d;
      db_q    <= db_d;
      dg_q    <= dg_d;
      dt_q    <= dt_d;
      side8_q <= side7_q;
      rem_q   <= rem_d;
      div_q   <= div_d;
      feed_q  <= feed_d;
    end
  end

  assign ctl_o  = ctl8_q;
  assign side_o = side8_q;
  assign rem_o  = rem_q;
  assign div_o  = div_q;
  assign feed_o = feed_q;

endmodule

### src/rti_div_step.sv
// ----------------------------------------------------------------------------
// rti_div_step: one stage of the restoring divider
// Shifts in one dividend bit, subtracts the divisor when it fits and shifts
// the resulting quotient bit into the bottom of the feed register.
// ----------------------------------------------------------------------------
module rti_div_step #(
  parameter int DVW = 66,
  parameter int NB  = rti_pkg::DistWidthDef,
  parameter int SW  = 6 * rti_pkg::CoordWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  rti_pkg::ctl_t ctl_i,
  input  logic [SW-1:0] side_i,
  input  logic [DVW-1:0] rem_i,
  input  logic [DVW-1:0] div_i,
  input  logic [NB-1:0] qf_i,
  output rti_pkg::ctl_t ctl_o,
  output logic [SW-1:0] side_o,
  output logic [DVW-1:0] rem_o,
  output logic [DVW-1:0] div_o,
  output logic [NB-1:0] qf_o
);
  import rti_pkg::*;

  logic [DVW:0]   remx, diff;
  logic           ge;
  ctl_t           ctl_q;
  logic [SW-1:0]  side_q;
  logic [DVW-1:0] rem_q, div_q;
  logic [NB-1:0]  qf_q;

  always_comb begin
    remx = {rem_i, qf_i[NB-1]};
    diff = remx - {1'b0, div_i};
    ge   = remx >= {1'b0, div_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      div_q  <= div_i;
      rem_q  <= ge ? diff[DVW-1:0] : remx[DVW-1:0];
      qf_q   <= {qf_i[NB-2:0], ge};
    end
  end

  assign ctl_o  = ctl_q;
  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign div_o  = div_q;
  assign qf_o   = qf_q;

endmodule

### src/rti_point.sv
// ----------------------------------------------------------------------------
// rti_point: distance check, hit point and result register
// Saturates the quotient, applies the minimum distance of the query kind,
// computes O + D*t per axis with saturation and forms the result item.
// ----------------------------------------------------------------------------
module rti_point #(
  parameter int CW    = rti_pkg::CoordWidthDef,
  parameter int DISTW = rti_pkg::DistWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  rti_pkg::ctl_t                 ctl_i,
  input  logic [6*CW-1:0]               side_i,
  input  logic [DISTW-1:0]              q_i,
  input  logic [rti_pkg::MinWidth-1:0]  min_p_i,
  input  logic [rti_pkg::MinWidth-1:0]  min_s_i,
  input  logic [3*CW-1:0]               normal_i,
  output logic                          valid_o,
  output logic                          hit_o,
  output logic [DISTW-1:0]              distance_o,
  output logic [3*CW-1:0]               point_o,
  output logic [3*CW-1:0]               normal_o
);
  import rti_pkg::*;

  localparam int DF   = DISTW / 2;
  localparam int PW   = CW + DISTW + 1;
  localparam int SUMW = PW - DF + 1;
  localparam int CMPW = (DISTW > MinWidth) ? DISTW : MinWidth;

  ctl_t                 ctla_d, ctla_q, ctlb_q, ctlc_q;
  logic [6*CW-1:0]      sidea_q;
  logic [3*CW-1:0]      orgb_q;
  logic [DISTW-1:0]     dista_d, dista_q, distb_q;
  logic [MinWidth-1:0]  minimum;
  logic signed [PW-1:0] prod_d [3], prod_q [3];
  logic signed [SUMW-1:0] sum, lo_lim, hi_lim;
  logic [3*CW-1:0]      pt_d, nrm_d;
  logic                 keep;
  logic                 hit_q;
  logic [DISTW-1:0]     dist_q;
  logic [3*CW-1:0]      pt_q, nrm_q;

  // Stage A: saturation and minimum distance.
  always_comb begin
    minimum     = ctl_i.shadow ? min_s_i : min_p_i;
    ctla_d      = ctl_i;
    ctla_d.live = ctl_i.live && !(!ctl_i.ovf && (CMPW'(q_i) < CMPW'(minimum)));
    dista_d     = ctl_i.ovf ? '1 : q_i;
  end

  // Stage B: D * t per axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = PW'($signed(sidea_q[3*CW-1-i*CW -: CW])) * PW'($signed({1'b0, dista_q}));
    end
  end

  // Stage C: add the origin, saturate and mask by hit and query kind.
  always_comb begin
    lo_lim = SUMW'($signed({1'b1, {(CW-1){1'b0}}}));
    hi_lim = SUMW'($signed({1'b0, {(CW-1){1'b1}}}));
    keep   = ctlb_q.live && !ctlb_q.shadow;
    for (int i = 0; i < 3; i++) begin
      sum = SUMW'($signed(orgb_q[3*CW-1-i*CW -: CW])) + SUMW'(prod_q[i] >>> DF);
      if (sum < lo_lim) begin
        sum = lo_lim;
      end else if (sum > hi_lim) begin
        sum = hi_lim;
      end
      pt_d[3*CW-1-i*CW -: CW]  = keep ? sum[CW-1:0] : '0;
      nrm_d[3*CW-1-i*CW -: CW] = keep ? normal_i[3*CW-1-i*CW -: CW] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctla_q <= '0;
      ctlb_q <= '0;
      ctlc_q <= '0;
    end else if (en_i) begin
      ctla_q <= ctla_d;
      ctlb_q <= ctla_q;
      ctlc_q <= ctlb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sidea_q <= side_i;
      dista_q <= dista_d;
      orgb_q  <= sidea_q[6*CW-1:3*CW];
      distb_q <= dista_q;
      prod_q  <= prod_d;
      hit_q   <= ctlb_q.live;
      dist_q  <= ctlb_q.live ? distb_q : '0;
      pt_q    <= pt_d;
      nrm_q   <= nrm_d;
    end
  end

  assign valid_o    = ctlc_q.valid;
  assign hit_o      = hit_q;
  assign distance_o = dist_q;
  assign point_o    = pt_q;
  assign normal_o   = nrm_q;

endmodule

### src/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect: ray against one configured triangle
// Cramer's rule intersection with a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Usage: each input item is a ray (origin, direction, Q10.10) plus an opcode,
// primary or shadow query, offered with valid_i and taken when stall_o is low.
// Each item yields exactly one result item on valid_o/stall_i, in order: hit
// flag, distance in Q16.16 and, for primary hits, hit point and normal.
// Throughput is one item per clock while stall_i does not hold the output.
// Six stages form the four determinants, two normalize signs and test the
// hit, one divider stage per distance bit produces the quotient, and three
// stages form the hit point and the result.
// The whole pipeline advances as one; when the result register holds an
// item and stall_i is high, it freezes and stall_o goes high, so nothing is
// lost or repeated. Empty slots still move while the output is free.
// Reset clears all valid bits and loads the default triangle A=(1,0,0),
// B=(0,1,0), C=(0,0,1), normal (0,1,0), minimum distances 1 and 66 LSB.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect at
// once; the user must make them only while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::CoordWidthDef,
  parameter int DIST_WIDTH  = rti_pkg::DistWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic                             opcode_i,
  input  logic signed [COORD_WIDTH-1:0]    origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]    origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]    origin_z_i,
  input  logic signed [COORD_WIDTH-1:0]    dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]    dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]    dir_z_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic                             hit_o,
  output logic [DIST_WIDTH-1:0]            distance_o,
  output logic signed [COORD_WIDTH-1:0]    point_x_o,
  output logic signed [COORD_WIDTH-1:0]    point_y_o,
  output logic signed [COORD_WIDTH-1:0]    point_z_o,
  output logic signed [COORD_WIDTH-1:0]    normal_x_o,
  output logic signed [COORD_WIDTH-1:0]    normal_y_o,
  output logic signed [COORD_WIDTH-1:0]    normal_z_o,
  input  logic                             cfg_we_i,
  input  logic [rti_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [3*COORD_WIDTH-1:0]         cfg_data_i
);
  import rti_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FRAC = CW / 2;
  localparam int DETW = det_width(CW);
  localparam int SW   = 6 * CW;
  localparam logic [CW-1:0] CoordOne  = {{(CW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
  localparam logic [CW-1:0] CoordZero = '0;

  // Configuration registers.
  logic [3*CW-1:0]     vtx_a_q, vtx_b_q, vtx_c_q, normal_q;
  logic [MinWidth-1:0] min_p_q, min_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_a_q  <= {CoordOne, CoordZero, CoordZero};
      vtx_b_q  <= {CoordZero, CoordOne, CoordZero};
      vtx_c_q  <= {CoordZero, CoordZero, CoordOne};
      normal_q <= {CoordZero, CoordOne, CoordZero};
      min_p_q  <= MinWidth'(1);
      min_s_q  <= MinWidth'(66);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_VERTEX_A:       vtx_a_q  <= cfg_data_i;
        REG_VERTEX_B:       vtx_b_q  <= cfg_data_i;
        REG_VERTEX_C:       vtx_c_q  <= cfg_data_i;
        REG_SURFACE_NORMAL: normal_q <= cfg_data_i;
        REG_MIN_PRIMARY:    min_p_q  <= cfg_data_i[MinWidth-1:0];
        REG_MIN_SHADOW:     min_s_q  <= cfg_data_i[MinWidth-1:0];
        default: ;
      endcase
    end
  end

  // One global advance: the pipeline moves unless a finished result is
  // being held back by the receiver.
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  ctl_t            ctl_in;
  logic [SW-1:0]   side_in;

  always_comb begin
    ctl_in        = '0;
    ctl_in.valid  = valid_i;
    ctl_in.shadow = opcode_i;
    ctl_in.live   = 1'b1;
    side_in       = {origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i};
  end

  ctl_t                   ctl_det;
  logic [SW-1:0]          side_det;
  logic signed [DETW-1:0] det, db, dg, dt;

  rti_det #(.CW(CW)) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl_in),
    .side_i  (side_in),
    .vtx_a_i (vtx_a_q),
    .vtx_b_i (vtx_b_q),
    .vtx_c_i (vtx_c_q),
    .ctl_o   (ctl_det),
    .side_o  (side_det),
    .det_o   (det),
    .db_o    (db),
    .dg_o    (dg),
    .dt_o    (dt)
  );

  // Divider chain: slot 0 is the check stage output, slot N the quotient.
  ctl_t            ctl_dv  [DIST_WIDTH+1];
  logic [SW-1:0]   side_dv [DIST_WIDTH+1];
  logic [DETW-1:0] rem_dv  [DIST_WIDTH+1];
  logic [DETW-1:0] div_dv  [DIST_WIDTH+1];
  logic [DIST_WIDTH-1:0] qf_dv [DIST_WIDTH+1];

  rti_check #(.CW(CW), .DISTW(DIST_WIDTH)) u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_det),
    .side_i (side_det),
    .det_i  (det),
    .db_i   (db),
    .dg_i   (dg),
    .dt_i   (dt),
    .ctl_o  (ctl_dv[0]),
    .side_o (side_dv[0]),
    .rem_o  (rem_dv[0]),
    .div_o  (div_dv[0]),
    .feed_o (qf_dv[0])
  );

  for (genvar g = 0; g < DIST_WIDTH; g++) begin : g_div
    rti_div_step #(.DVW(DETW), .NB(DIST_WIDTH), .SW(SW)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_dv[g]),
      .side_i (side_dv[g]),
      .rem_i  (rem_dv[g]),
      .div_i  (div_dv[g]),
      .qf_i   (qf_dv[g]),
      .ctl_o  (ctl_dv[g+1]),
      .side_o (side_dv[g+1]),
      .rem_o  (rem_dv[g+1]),
      .div_o  (div_dv[g+1]),
      .qf_o   (qf_dv[g+1])
    );
  end

  // The final remainder and divisor are not needed by the result stages.
  logic [3*CW-1:0] point_w, normal_w;

  rti_point #(.CW(CW), .DISTW(DIST_WIDTH)) u_point (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (ctl_dv[DIST_WIDTH]),
    .side_i     (side_dv[DIST_WIDTH]),
    .q_i        (qf_dv[DIST_WIDTH] ^ {DIST_WIDTH{rem_dv[DIST_WIDTH] != rem_dv[DIST_WIDTH]}}
                 ^ {DIST_WIDTH{div_dv[DIST_WIDTH] != div_dv[DIST_WIDTH]}}),
    .min_p_i    (min_p_q),
    .min_s_i    (min_s_q),
    .normal_i   (normal_q),
    .valid_o    (valid_o),
    .hit_o      (hit_o),
    .distance_o (distance_o),
    .point_o    (point_w),
    .normal_o   (normal_w)
  );

  assign point_x_o  = point_w[3*CW-1:2*CW];
  assign point_y_o  = point_w[2*CW-1:CW];
  assign point_z_o  = point_w[CW-1:0];
  assign normal_x_o = normal_w[3*CW-1:2*CW];
  assign normal_y_o = normal_w[2*CW-1:CW];
  assign normal_z_o = normal_w[CW-1:0];

  // A miss reports all-zero fields; checked on the distance, point x and normal y.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> distance_o == '0 && point_x_o == '0 && normal_y_o == '0)
    else $error("miss with nonzero fields");

  // A nonzero normal appears only on a hit.
  a_normal_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0) |-> hit_o)
    else $error("normal reported without hit");

  // The input is held back only while a result waits on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output back-pressure");

  // A held result leaves the result register unchanged in the next cycle.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(distance_o) && $stable(hit_o))
    else $error("held result changed");

endmodule

### bench/rti_checker.sv
// ----------------------------------------------------------------------------
// rti_checker: result predictor and scoreboard for ray_triangle_intersect
// Tracks the triangle registers from the write port, predicts the outcome of
// every accepted ray and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module rti_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic                                stall_o,
  input  logic                                opcode_i,
  input  logic signed [19:0]                  origin_x_i,
  input  logic signed [19:0]                  origin_y_i,
  input  logic signed [19:0]                  origin_z_i,
  input  logic signed [19:0]                  dir_x_i,
  input  logic signed [19:0]                  dir_y_i,
  input  logic signed [19:0]                  dir_z_i,
  input  logic                                valid_o,
  input  logic                                stall_i,
  input  logic                                hit_o,
  input  logic [31:0]                         distance_o,
  input  logic signed [19:0]                  point_x_o,
  input  logic signed [19:0]                  point_y_o,
  input  logic signed [19:0]                  point_z_o,
  input  logic signed [19:0]                  normal_x_o,
  input  logic signed [19:0]                  normal_y_o,
  input  logic signed [19:0]                  normal_z_o,
  input  logic                                cfg_we_i,
  input  logic [rti_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [59:0]                         cfg_data_i,
  output int                                  errors_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic               hit;
    logic [31:0]        dist_v;
    logic signed [19:0] pt[3];
    logic signed [19:0] nrm[3];
  } hit_rec_t;

  logic [59:0] vtx_a, vtx_b, vtx_c, nrm_reg;
  logic [16:0] min_pri, min_shd;
  hit_rec_t    hit_queue[$];

  function automatic wide_t coord(logic [59:0] r, int axis);
    case (axis)
      0:       return wide_t'($signed(r[59:40]));
      1:       return wide_t'($signed(r[39:20]));
      default: return wide_t'($signed(r[19:0]));
    endcase
  endfunction

  // Determinant of the 3x3 matrix with columns u, v, w.
  function automatic wide_t det3(wide_t u0, wide_t u1, wide_t u2, wide_t v0, wide_t v1,
                                 wide_t v2, wide_t w0, wide_t w1, wide_t w2);
    return u0 * (v1 * w2 - w1 * v2) - u1 * (v0 * w2 - w0 * v2) + u2 * (v0 * w1 - w0 * v1);
  endfunction

  function automatic hit_rec_t trace_ray(logic shadow, logic signed [19:0] org_x,
                                         logic signed [19:0] org_y, logic signed [19:0] org_z,
                                         logic signed [19:0] d_x, logic signed [19:0] d_y,
                                         logic signed [19:0] d_z);
    hit_rec_t r;
    wide_t    org[3], dv[3], e1[3], e2[3], rv[3];
    wide_t    det, db, dg, dt, quo, lim, pt;
    logic [31:0] sat_dist;
    r.hit = 1'b0;
    r.dist_v = '0;
    for (int i = 0; i < 3; i++) begin
      r.pt[i] = '0;
      r.nrm[i] = '0;
    end
    org[0] = wide_t'(org_x); org[1] = wide_t'(org_y); org[2] = wide_t'(org_z);
    dv[0] = wide_t'(d_x); dv[1] = wide_t'(d_y); dv[2] = wide_t'(d_z);
    for (int i = 0; i < 3; i++) begin
      e1[i] = coord(vtx_a, i) - coord(vtx_b, i);
      e2[i] = coord(vtx_a, i) - coord(vtx_c, i);
      rv[i] = coord(vtx_a, i) - org[i];
    end
    det = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], dv[0], dv[1], dv[2]);
    if (det == 0) return r;
    db = det3(rv[0], rv[1], rv[2], e2[0], e2[1], e2[2], dv[0], dv[1], dv[2]);
    dg = det3(e1[0], e1[1], e1[2], rv[0], rv[1], rv[2], dv[0], dv[1], dv[2]);
    dt = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], rv[0], rv[1], rv[2]);
    if (det < 0) begin
      det = -det; db = -db; dg = -dg; dt = -dt;
    end
    if (db < 0 || dg < 0 || det < db + dg || dt < 0) return r;
    quo = (dt <<< 16) / det;
    lim = shadow ? wide_t'({1'b0, min_shd}) : wide_t'({1'b0, min_pri});
    if (quo < lim) return r;
    sat_dist = (quo > wide_t'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : quo[31:0];
    r.hit = 1'b1;
    r.dist_v = sat_dist;
    if (shadow) return r;
    for (int i = 0; i < 3; i++) begin
      pt = org[i] + ((dv[i] * wide_t'({1'b0, sat_dist})) >>> 16);
      if (pt < -wide_t'(524288)) pt = -wide_t'(524288);
      if (pt > wide_t'(524287)) pt = wide_t'(524287);
      r.pt[i] = pt[19:0];
      r.nrm[i] = nrm_reg[59 - 20 * i -: 20];
    end
    return r;
  endfunction

  assign pending_o = hit_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    hit_rec_t exp_r;
    logic     bad;
    if (!rst_ni) begin
      vtx_a <= 60'd1125899906842624;
      vtx_b <= 60'd1073741824;
      vtx_c <= 60'd1024;
      nrm_reg <= 60'd1073741824;
      min_pri <= 17'd1;
      min_shd <= 17'd66;
      errors_o <= 0;
      hit_queue.delete();
    end else begin
      // Prediction uses the registers as they stand before this edge's write;
      // writes only happen while no ray is offered.
      if (valid_i && !stall_o)
        hit_queue.push_back(trace_ray(opcode_i, origin_x_i, origin_y_i, origin_z_i,
                                      dir_x_i, dir_y_i, dir_z_i));
      if (valid_o && !stall_i) begin
        if (hit_queue.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("ERROR: result item with nothing expected");
        end else begin
          exp_r = hit_queue.pop_front();
          bad = (hit_o !== exp_r.hit) || (distance_o !== exp_r.dist_v) ||
                (point_x_o !== exp_r.pt[0]) || (point_y_o !== exp_r.pt[1]) ||
                (point_z_o !== exp_r.pt[2]) || (normal_x_o !== exp_r.nrm[0]) ||
                (normal_y_o !== exp_r.nrm[1]) || (normal_z_o !== exp_r.nrm[2]);
          if (bad) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10)
              $display("ERROR: exp hit %0b dist %h pt %0d %0d %0d n %0d %0d %0d | got hit %0b dist %h pt %0d %0d %0d n %0d %0d %0d",
                       exp_r.hit, exp_r.dist_v, exp_r.pt[0], exp_r.pt[1], exp_r.pt[2],
                       exp_r.nrm[0], exp_r.nrm[1], exp_r.nrm[2], hit_o, distance_o,
                       point_x_o, point_y_o, point_z_o, normal_x_o, normal_y_o, normal_z_o);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VERTEX_A:       vtx_a <= cfg_data_i;
          REG_VERTEX_B:       vtx_b <= cfg_data_i;
          REG_VERTEX_C:       vtx_c <= cfg_data_i;
          REG_SURFACE_NORMAL: nrm_reg <= cfg_data_i;
          REG_MIN_PRIMARY:    min_pri <= cfg_data_i[16:0];
          REG_MIN_SHADOW:     min_shd <= cfg_data_i[16:0];
          default:            ;
        endcase
      end
    end
  end

endmodule

### bench/ray_triangle_intersect_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb: regression for the ray/triangle intersection unit
// Streams directed and random rays through several triangle setups with random
// gaps and output stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 60;
  // Indexes past the last register; writes to them must be dropped.
  localparam logic [CfgIdxWidth-1:0] IdxSpareLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] IdxSpareHi = 3'd7;

  logic clk_i, rst_ni;
  logic valid_i, stall_o, opcode_i, valid_o, stall_i, hit_o;
  logic signed [19:0] origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i;
  logic [31:0] distance_o;
  logic signed [19:0] point_x_o, point_y_o, point_z_o, normal_x_o, normal_y_o, normal_z_o;
  logic cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [59:0] cfg_data_i;
  int errors, pending, idle_cycles;
  bit quiet_sender, quiet_receiver;

  // Stimulus-side copy of the vertices, used only to aim rays at the triangle.
  longint vert[3][3];

  ray_triangle_intersect dut (.*);

  rti_checker u_checker (
    .clk_i, .rst_ni, .valid_i, .stall_o, .opcode_i, .origin_x_i, .origin_y_i,
    .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i, .valid_o, .stall_i, .hit_o,
    .distance_o, .point_x_o, .point_y_o, .point_z_o, .normal_x_o, .normal_y_o,
    .normal_z_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [19:0] clamp20(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  // Receiver side: random stall runs, with quiet stretches where it never stalls.
  initial begin
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall_i <= 1'b0;
      repeat (quiet_receiver ? 20 : gap_len() + 1) @(negedge clk_i);
      if (!quiet_receiver) begin
        stall_i <= 1'b1;
        repeat (gap_len()) @(negedge clk_i);
      end
    end
  end

  // The watchdog ends the run when no item moves on either side for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i) || !rst_ni) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("ray_triangle_intersect regression: fail");
        $finish;
      end
    end
  end

  // Writes one register; called at a falling edge while the block is idle.
  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [59:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_triangle(longint a[3], longint b[3], longint c[3]);
    logic [59:0] w[3];
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        vert[v][i] = (v == 0) ? a[i] : (v == 1) ? b[i] : c[i];
        w[v][59 - 20 * i -: 20] = clamp20(vert[v][i]);
      end
    end
    write_reg(REG_VERTEX_A, w[0]);
    write_reg(REG_VERTEX_B, w[1]);
    write_reg(REG_VERTEX_C, w[2]);
  endtask

  // Offers one ray and holds it until it is taken.
  task automatic send_ray(logic shd, longint ox, longint oy, longint oz,
                          longint dx, longint dy, longint dz);
    int gap;
    gap = quiet_sender ? 0 : gap_len();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    opcode_i <= shd;
    origin_x_i <= clamp20(ox); origin_y_i <= clamp20(oy); origin_z_i <= clamp20(oz);
    dir_x_i <= clamp20(dx); dir_y_i <= clamp20(dy); dir_z_i <= clamp20(dz);
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // A ray aimed at a random point of the triangle, started a few steps back.
  task automatic send_aimed_ray(int span);
    longint w0, w1, w2, p[3], d[3], k;
    w0 = $urandom_range(0, 1024);
    w1 = $urandom_range(0, 1024 - w0);
    w2 = 1024 - w0 - w1;
    k = $urandom_range(0, 6);
    for (int i = 0; i < 3; i++) begin
      p[i] = (w0 * vert[0][i] + w1 * vert[1][i] + w2 * vert[2][i]) / 1024;
      d[i] = longint'($urandom_range(0, 2 * span)) - span;
    end
    send_ray(1'($urandom_range(0, 1)), p[0] - d[0] * k, p[1] - d[1] * k, p[2] - d[2] * k,
             d[0], d[1], d[2]);
  endtask

  task automatic send_noise_ray();
    send_ray(1'($urandom_range(0, 1)), $signed(20'($urandom)), $signed(20'($urandom)),
             $signed(20'($urandom)), $signed(20'($urandom)), $signed(20'($urandom)),
             $signed(20'($urandom)));
  endtask

  // Waits for every outstanding result before the registers change.
  task automatic drain();
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic random_phase(int count, int span);
    quiet_sender = ($urandom_range(0, 3) == 0);
    quiet_receiver = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 75) send_aimed_ray(span);
      else send_noise_ray();
    end
    quiet_sender = 0;
    quiet_receiver = 0;
    drain();
  endtask

  initial begin
    longint a[3], b[3], c[3];
    rst_ni = 1'b0;
    valid_i = 1'b0;
    opcode_i = 1'b0;
    {origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i} = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_VERTEX_A;
    cfg_data_i = '0;
    vert[0] = '{1024, 0, 0};
    vert[1] = '{0, 1024, 0};
    vert[2] = '{0, 0, 1024};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rays against the reset triangle.
    send_ray(0, 0, 0, 0, 341, 341, 341);            // primary hit at the centroid
    send_ray(1, 0, 0, 0, 341, 341, 341);            // shadow hit, no point or normal
    send_ray(0, 0, 0, 0, 1024, 0, 0);               // hit on vertex A, beta and gamma zero
    send_ray(0, 0, 0, 0, 0, 1024, 0);               // on vertex B
    send_ray(0, 0, 0, 0, 512, 512, 0);              // on edge AB, gamma zero
    send_ray(0, 0, 0, 0, 1024, -1024, 0);           // parallel to the plane, zero determinant
    send_ray(0, 0, 0, 0, 0, 0, 0);                  // zero direction
    send_ray(0, 0, 0, 0, -341, -341, -341);         // triangle behind the origin
    send_ray(0, 0, 0, 0, 1024, 1024, -1024);        // outside the triangle
    send_ray(0, -512000, -512000, -512000, 1, 1, 1); // distance saturates
    send_ray(1, -512000, -512000, -512000, 1, 1, 1);
    send_ray(0, 341, 341, 342, 1, 1, 1);            // origin on the plane, zero distance
    send_ray(1, 341, 341, 341, 1, 1, 1);            // short shadow distance, still above the minimum
    send_ray(0, -524288, -524288, -524288, 524287, 524287, 524287);
    send_ray(1, 524287, 524287, 524287, -524288, -524288, -524288);
    send_ray(0, 524287, -524288, 524287, -524288, 524287, -524288);
    send_ray(0, 0, 0, 0, -524288, -524288, -524288);
    drain();

    // Zero minimums, spare-index writes that must be ignored, new normal.
    write_reg(REG_MIN_PRIMARY, {43'h123_4567_89AB, 17'd0});
    write_reg(REG_MIN_SHADOW, 60'd0);
    write_reg(REG_SURFACE_NORMAL, {20'sd524287, -20'sd524288, 20'sd1});
    write_reg(IdxSpareLo, 60'd0);
    write_reg(IdxSpareHi, {60{1'b1}});
    a = '{2048, -1024, 300}; b = '{-3000, 2500, 100}; c = '{500, 1800, -2200};
    set_triangle(a, b, c);
    send_ray(0, 0, 0, 0, 0, 0, 0);
    send_ray(1, -200, 1000, 5000, 0, 0, -1024);
    random_phase(170, 2048);

    // A large primary minimum, the largest shadow minimum and a triangle spanning the full coordinate range.
    write_reg(REG_MIN_PRIMARY, 60'd65536);
    write_reg(REG_MIN_SHADOW, 60'h1FFFF);
    write_reg(REG_SURFACE_NORMAL, {60{1'b1}});
    a = '{524287, -524288, 0}; b = '{-524288, 524287, 524287}; c = '{0, 0, -524288};
    set_triangle(a, b, c);
    random_phase(170, 200000);

    // Random setups of moderate size.
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_MIN_PRIMARY, 60'($urandom_range(0, 2000)));
      write_reg(REG_MIN_SHADOW, 60'($urandom_range(0, 131071)));
      write_reg(REG_SURFACE_NORMAL, {28'($urandom), 32'($urandom)});
      for (int i = 0; i < 3; i++) begin
        a[i] = longint'($urandom_range(0, 16383)) - 8192;
        b[i] = longint'($urandom_range(0, 16383)) - 8192;
        c[i] = longint'($urandom_range(0, 16383)) - 8192;
      end
      set_triangle(a, b, c);
      random_phase(165, 4096);
    end

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("ray_triangle_intersect regression: pass");
    end else begin
      $display("ray_triangle_intersect regression: fail");
    end
    $finish;
  end

endmodule
